// File: rtl/ppra_pkg.sv
// shared types and constants for the physical page region allocator
package ppra_pkg;

   localparam int MAX_REGIONS  = 128;
   localparam int MAX_RESERVED = 32;
   localparam int PAGE_W       = 32;
   localparam int IDX_W        = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W        = $clog2(MAX_REGIONS + 1);
   localparam int RCNT_W       = $clog2(MAX_RESERVED + 1);

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_LOW   = 2'd1,
      CMD_HIGH  = 2'd2,
      CMD_CHECK = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_NONE       = 2'd1,
      STS_TABLE_FULL = 2'd2,
      STS_RSV_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SCAN_LOW   = 2'd0,
      SCAN_RSV   = 2'd1,
      SCAN_CHECK = 2'd2,
      SCAN_HIGH  = 2'd3
   } scan_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_FWD  = 2'd1,
      FSM_BWD  = 2'd2
   } fsm_type;

   typedef struct packed {
      logic              valid;
      logic              found;
      logic [PAGE_W-1:0] page;
      logic [IDX_W-1:0]  idx;
   } wave_type;

   typedef struct packed {
      logic              start;
      scan_type          mode;
      logic [IDX_W-1:0]  start_idx;
      logic [CNT_W-1:0]  count;
      logic [PAGE_W-1:0] query;
      logic              load_we;
      logic [IDX_W-1:0]  load_idx;
      logic [PAGE_W-1:0] ld_base;
      logic [PAGE_W-1:0] ld_end;
      logic [PAGE_W-1:0] ld_lo;
      logic [PAGE_W-1:0] ld_hi;
      logic              ld_rsv;
   } ctl_type;

endpackage

// File: rtl/physical_page_region_allocator_unit.sv
// top level: command sequencer and the chain of region cells
// a load is answered from the result register without a wave; check, low allocation and
// reserved pass walk a wave from the start cell to the end of the cell chain one cell per cycle;
// a high allocation that misses the reserved regions adds a downward pass from the top region
// throughput: one item at a time, next item accepted once the result is taken
// reset: synchronous, clears counts, pointers of the scan, watermarks and the waves
module physical_page_region_allocator_unit import ppra_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic [PAGE_W-1:0] req_region_first,
   input  logic [PAGE_W-1:0] req_region_last,
   input  logic [PAGE_W-1:0] req_first_free,
   input  logic [PAGE_W-1:0] req_last_free,
   input  logic              req_keep_reserved,
   input  logic [PAGE_W-1:0] req_query_page,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [PAGE_W-1:0] rsp_page,
   output logic [PAGE_W-1:0] rsp_pages_remaining,
   output logic [PAGE_W-1:0] rsp_highest_given,
   output logic [PAGE_W-1:0] rsp_lowest_given,
   output logic [PAGE_W-1:0] rsp_lowest_high_given,
   output logic [PAGE_W-1:0] rsp_highest_high_given,
   output logic [PAGE_W-1:0] rsp_reserved_given
);

   // sequencer state
   fsm_type           state_ff, state_in;
   scan_type          mode_ff, mode_in;
   logic              start_ff, start_in;
   logic [IDX_W-1:0]  start_idx_ff, start_idx_in;
   logic [PAGE_W-1:0] query_ff, query_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [RCNT_W-1:0] rcount_ff, rcount_in;

   // allocator counters and watermarks
   logic [PAGE_W-1:0] pages_ff, pages_in;
   logic [PAGE_W-1:0] max_ff, max_in, min_ff, min_in;
   logic [PAGE_W-1:0] minh_ff, minh_in, maxh_ff, maxh_in;
   logic [PAGE_W-1:0] rgrants_ff, rgrants_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [PAGE_W-1:0] page_ff, page_in;

   logic              accept, rsv_full, tbl_full;
   logic              grant, grant_high;
   logic [PAGE_W-1:0] grant_page, pages_dec, add_pages;
   logic [PAGE_W:0]   pages_sum;
   cmd_type           cmd;
   ctl_type           ctl;
   wave_type          fwd_exit, bwd_exit;
   wave_type          fwd_w [MAX_REGIONS];
   wave_type          bwd_w [MAX_REGIONS];

   assign req_ready = (state_ff == FSM_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         scan_ff      <= '0;
         rcount_ff    <= '0;
         pages_ff     <= '0;
         max_ff       <= '0;
         min_ff       <= '0;
         minh_ff      <= '0;
         maxh_ff      <= '0;
         rgrants_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rcount_ff    <= rcount_in;
         pages_ff     <= pages_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         minh_ff      <= minh_in;
         maxh_ff      <= maxh_in;
         rgrants_ff   <= rgrants_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      start_idx_ff <= start_idx_in;
      query_ff     <= query_in;
      status_ff    <= status_in;
      page_ff      <= page_in;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      start_in     = 1'b0;
      start_idx_in = start_idx_ff;
      query_in     = query_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      rcount_in    = rcount_ff;
      rgrants_in   = rgrants_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      page_in      = page_ff;
      grant        = 1'b0;
      grant_high   = 1'b0;
      grant_page   = '0;

      tbl_full  = count_ff >= CNT_W'(MAX_REGIONS);
      rsv_full  = req_keep_reserved && (rcount_ff >= RCNT_W'(MAX_RESERVED));
      // a load adds last minus first, nothing for an inverted region
      add_pages = (req_region_last >= req_region_first) ?
                  (req_region_last - req_region_first) : '0;
      pages_sum = {1'b0, pages_ff} + {1'b0, add_pages};
      pages_dec = pages_ff;

      ctl           = '0;
      ctl.start     = start_ff;
      ctl.mode      = mode_ff;
      ctl.start_idx = start_idx_ff;
      ctl.count     = count_ff;
      ctl.query     = query_ff;
      ctl.load_idx  = count_ff[IDX_W-1:0];
      ctl.ld_base   = req_region_first;
      ctl.ld_end    = req_region_last;
      ctl.ld_lo     = req_first_free;
      ctl.ld_hi     = req_last_free;
      ctl.ld_rsv    = req_keep_reserved;

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_LOAD: begin
                     rsp_valid_in = 1'b1;
                     page_in      = '0;
                     if (tbl_full) begin
                        status_in = STS_TABLE_FULL;
                     end else if (rsv_full) begin
                        status_in = STS_RSV_FULL;
                     end else begin
                        status_in   = STS_OK;
                        ctl.load_we = 1'b1;
                        count_in    = count_ff + 1'b1;
                        if (req_keep_reserved) begin
                           rcount_in = rcount_ff + 1'b1;
                        end
                        pages_dec = pages_sum[PAGE_W] ? '1 : pages_sum[PAGE_W-1:0];
                     end
                  end
                  CMD_LOW: begin
                     if (pages_ff == '0 || scan_ff >= count_ff) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STS_NONE;
                        page_in      = '0;
                     end else begin
                        start_in     = 1'b1;
                        mode_in      = SCAN_LOW;
                        start_idx_in = scan_ff[IDX_W-1:0];
                        state_in     = FSM_FWD;
                     end
                  end
                  CMD_HIGH: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STS_NONE;
                        page_in      = '0;
                     end else begin
                        // reserved regions first, in load order
                        start_in     = 1'b1;
                        mode_in      = SCAN_RSV;
                        start_idx_in = '0;
                        state_in     = FSM_FWD;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STS_NONE;
                        page_in      = '0;
                     end else begin
                        start_in     = 1'b1;
                        mode_in      = SCAN_CHECK;
                        start_idx_in = '0;
                        query_in     = req_query_page;
                        state_in     = FSM_FWD;
                     end
                  end
               endcase
            end
         end
         FSM_FWD: begin
            if (fwd_exit.valid) begin
               state_in  = FSM_IDLE;
               status_in = fwd_exit.found ? STS_OK : STS_NONE;
               page_in   = '0;
               unique case (mode_ff)
                  SCAN_LOW: begin
                     rsp_valid_in = 1'b1;
                     if (fwd_exit.found) begin
                        grant      = 1'b1;
                        grant_page = fwd_exit.page;
                        page_in    = fwd_exit.page;
                        scan_in    = CNT_W'(fwd_exit.idx);
                     end else begin
                        scan_in = count_ff;
                     end
                  end
                  SCAN_RSV: begin
                     if (fwd_exit.found) begin
                        rsp_valid_in = 1'b1;
                        grant        = 1'b1;
                        grant_page   = fwd_exit.page;
                        page_in      = fwd_exit.page;
                        rgrants_in   = rgrants_ff + 1'b1;
                     end else if (pages_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        // fall back to the downward scan from the top region
                        start_in     = 1'b1;
                        mode_in      = SCAN_HIGH;
                        start_idx_in = IDX_W'(count_ff - 1'b1);
                        state_in     = FSM_BWD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            if (bwd_exit.valid) begin
               state_in     = FSM_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = bwd_exit.found ? STS_OK : STS_NONE;
               page_in      = bwd_exit.found ? bwd_exit.page : '0;
               grant        = bwd_exit.found;
               grant_high   = bwd_exit.found;
               grant_page   = bwd_exit.page;
            end
         end
      endcase

      // bookkeeping for a granted page
      pages_in = pages_dec;
      max_in   = max_ff;
      min_in   = min_ff;
      minh_in  = minh_ff;
      maxh_in  = maxh_ff;
      if (grant) begin
         if (pages_ff != '0) begin
            pages_in = pages_ff - 1'b1;
         end
         if (grant_page > max_ff) begin
            max_in = grant_page;
         end
         if (min_ff == '0 || grant_page < min_ff) begin
            min_in = grant_page;
         end
      end
      if (grant_high) begin
         if (minh_ff == '0 || grant_page < minh_ff) begin
            minh_in = grant_page;
         end
         if (grant_page > maxh_ff) begin
            maxh_in = grant_page;
         end
      end
   end

   // region cells: forward wave walks upward, backward wave walks downward
   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      wave_type fin, bin;
      if (i == 0) begin : g_first
         assign fin = '0;
      end else begin : g_mid
         assign fin = fwd_w[i-1];
      end
      if (i == MAX_REGIONS - 1) begin : g_last
         assign bin = '0;
      end else begin : g_body
         assign bin = bwd_w[i+1];
      end
      ppra_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .ctl        (ctl),
         .fwd_in     (fin),
         .bwd_in     (bin),
         .fwd_out    (fwd_w[i]),
         .bwd_out    (bwd_w[i])
      );
   end

   assign fwd_exit = fwd_w[MAX_REGIONS-1];
   assign bwd_exit = bwd_w[0];

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_page               = page_ff;
   assign rsp_pages_remaining    = pages_ff;
   assign rsp_highest_given      = max_ff;
   assign rsp_lowest_given       = min_ff;
   assign rsp_lowest_high_given  = minh_ff;
   assign rsp_highest_high_given = maxh_ff;
   assign rsp_reserved_given     = rgrants_ff;

endmodule

// File: rtl/ppra_cell.sv
// one region cell: holds a region entry and passes the search waves on
module ppra_cell import ppra_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_index,
   input  ctl_type          ctl,
   input  wave_type         fwd_in,
   input  wave_type         bwd_in,
   output wave_type         fwd_out,
   output wave_type         bwd_out
);

   logic [PAGE_W-1:0] base_ff, end_ff, lo_ff, hi_ff;
   logic [PAGE_W-1:0] lo_in, hi_in;
   logic              rsv_ff;
   wave_type          fwd_ff, fwd_in_w, bwd_ff, bwd_in_w;
   wave_type          fw, bw;
   logic              live, inject, has_pages, pred, hit_f, hit_b, load_me;

   always_comb begin
      live      = CNT_W'(cell_index) < ctl.count;
      inject    = ctl.start && (cell_index == ctl.start_idx);
      has_pages = lo_ff <= hi_ff;
      load_me   = ctl.load_we && (ctl.load_idx == cell_index);

      fw = fwd_in;
      if (inject && ctl.mode != SCAN_HIGH) begin
         fw = '0;
         fw.valid = 1'b1;
      end
      bw = bwd_in;
      if (inject && ctl.mode == SCAN_HIGH) begin
         bw = '0;
         bw.valid = 1'b1;
      end

      unique case (ctl.mode)
         SCAN_LOW:   pred = has_pages;
         SCAN_RSV:   pred = has_pages && rsv_ff;
         SCAN_CHECK: pred = (ctl.query >= base_ff) && (ctl.query <= end_ff);
         default:    pred = 1'b0;
      endcase

      hit_f = fw.valid && !fw.found && live && pred;
      hit_b = bw.valid && !bw.found && live && has_pages;

      fwd_in_w = fw;
      lo_in    = lo_ff;
      if (hit_f) begin
         fwd_in_w.found = 1'b1;
         fwd_in_w.page  = lo_ff;
         fwd_in_w.idx   = cell_index;
         if (ctl.mode != SCAN_CHECK) begin
            lo_in = lo_ff + 1'b1;
         end
      end
      bwd_in_w = bw;
      hi_in    = hi_ff;
      if (hit_b) begin
         bwd_in_w.found = 1'b1;
         bwd_in_w.page  = hi_ff;
         bwd_in_w.idx   = cell_index;
         hi_in          = hi_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
         bwd_ff <= '0;
      end else begin
         fwd_ff <= fwd_in_w;
         bwd_ff <= bwd_in_w;
      end
      if (load_me) begin
         base_ff <= ctl.ld_base;
         end_ff  <= ctl.ld_end;
         lo_ff   <= ctl.ld_lo;
         hi_ff   <= ctl.ld_hi;
         rsv_ff  <= ctl.ld_rsv;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign fwd_out = fwd_ff;
   assign bwd_out = bwd_ff;

endmodule

// File: bench/physical_page_region_allocator_unit_checker.sv
// checker: predicts allocator results from accepted items and compares them
`timescale 1ns / 100ps
module physical_page_region_allocator_unit_checker import ppra_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic [PAGE_W-1:0] req_region_first,
   input  logic [PAGE_W-1:0] req_region_last,
   input  logic [PAGE_W-1:0] req_first_free,
   input  logic [PAGE_W-1:0] req_last_free,
   input  logic              req_keep_reserved,
   input  logic [PAGE_W-1:0] req_query_page,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [1:0]        rsp_status,
   input  logic [PAGE_W-1:0] rsp_page,
   input  logic [PAGE_W-1:0] rsp_pages_remaining,
   input  logic [PAGE_W-1:0] rsp_highest_given,
   input  logic [PAGE_W-1:0] rsp_lowest_given,
   input  logic [PAGE_W-1:0] rsp_lowest_high_given,
   input  logic [PAGE_W-1:0] rsp_highest_high_given,
   input  logic [PAGE_W-1:0] rsp_reserved_given,
   output int                fail_count,
   output int                pending_count,
   output int                grant_count
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] page;
      logic [31:0] left;
      logic [31:0] hi_max;
      logic [31:0] lo_min;
      logic [31:0] hs_min;
      logic [31:0] hs_max;
      logic [31:0] rsv_cnt;
   } grant_rec;

   logic [31:0] base_q [MAX_REGIONS];
   logic [31:0] end_q  [MAX_REGIONS];
   logic [31:0] lo_q   [MAX_REGIONS];
   logic [31:0] hi_q   [MAX_REGIONS];
   int          rsv_idx [MAX_RESERVED];
   int          n_regions, cursor, n_rsv;
   logic [31:0] left, hi_max, lo_min, hs_min, hs_max, rsv_cnt;
   grant_rec    grants_due [$];

   function automatic void note_page(logic [31:0] pg);
      if (left != 0) left--;
      if (pg > hi_max) hi_max = pg;
      if (lo_min == 0 || pg < lo_min) lo_min = pg;
   endfunction

   function automatic grant_rec predict_grant(logic [1:0] cmd, logic [31:0] first,
                                              logic [31:0] last, logic [31:0] ff,
                                              logic [31:0] lf, logic rsv,
                                              logic [31:0] q);
      grant_rec g;
      logic     hit;
      int       r;
      hit = 0;
      g = '0;
      g.status = STS_NONE;
      case (cmd)
         CMD_LOAD: begin
            if (n_regions >= MAX_REGIONS) g.status = STS_TABLE_FULL;
            else if (rsv && n_rsv >= MAX_RESERVED) g.status = STS_RSV_FULL;
            else begin
               base_q[n_regions] = first; end_q[n_regions] = last;
               lo_q[n_regions] = ff; hi_q[n_regions] = lf;
               if (rsv) begin rsv_idx[n_rsv] = n_regions; n_rsv++; end
               n_regions++;
               if (last >= first) begin
                  if (last - first > 32'hFFFF_FFFF - left) left = 32'hFFFF_FFFF;
                  else left = left + (last - first);
               end
               g.status = STS_OK;
            end
         end
         CMD_LOW: if (left != 0) begin
            while (!hit && cursor < n_regions) begin
               if (lo_q[cursor] > hi_q[cursor]) cursor++;
               else begin
                  g.page = lo_q[cursor]; lo_q[cursor]++; note_page(g.page); hit = 1;
               end
            end
            if (hit) g.status = STS_OK;
         end
         CMD_HIGH: begin
            // reserved regions first, from their low end, no count needed
            for (int n = 0; n < n_rsv && !hit; n++) begin
               r = rsv_idx[n];
               if (lo_q[r] <= hi_q[r]) begin
                  g.page = lo_q[r]; lo_q[r]++; note_page(g.page); rsv_cnt++; hit = 1;
               end
            end
            if (!hit && left != 0)
               for (int n = n_regions - 1; n >= 0 && !hit; n--)
                  if (hi_q[n] >= lo_q[n]) begin
                     g.page = hi_q[n]; hi_q[n]--; note_page(g.page);
                     if (hs_min == 0 || g.page < hs_min) hs_min = g.page;
                     if (g.page > hs_max) hs_max = g.page;
                     hit = 1;
                  end
            if (hit) g.status = STS_OK;
         end
         default: begin
            for (int n = 0; n < n_regions; n++)
               if (q >= base_q[n] && q <= end_q[n]) hit = 1;
            if (hit) g.status = STS_OK;
         end
      endcase
      if (g.status != STS_OK) g.page = 0;
      g.left = left; g.hi_max = hi_max; g.lo_min = lo_min;
      g.hs_min = hs_min; g.hs_max = hs_max; g.rsv_cnt = rsv_cnt;
      return g;
   endfunction

   assign pending_count = grants_due.size();

   always @(posedge clock) begin
      grant_rec want, got;
      if (reset) begin
         n_regions = 0; cursor = 0; n_rsv = 0;
         left = 0; hi_max = 0; lo_min = 0; hs_min = 0; hs_max = 0; rsv_cnt = 0;
         grants_due.delete();
         fail_count <= 0;
         grant_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_page, rsp_pages_remaining, rsp_highest_given,
                   rsp_lowest_given, rsp_lowest_high_given, rsp_highest_high_given,
                   rsp_reserved_given};
            grant_count <= grant_count + 1;
            if (grants_due.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = grants_due.pop_front();
               if (want !== got) begin
                  if (fail_count < 10)
                     $display("mismatch sts %0d/%0d page %h/%h left %h/%h max %h/%h min %h/%h hmin %h/%h hmax %h/%h rsv %h/%h",
                        want.status, got.status, want.page, got.page, want.left, got.left,
                        want.hi_max, got.hi_max, want.lo_min, got.lo_min,
                        want.hs_min, got.hs_min, want.hs_max, got.hs_max,
                        want.rsv_cnt, got.rsv_cnt);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            grants_due.push_back(predict_grant(req_command, req_region_first, req_region_last,
               req_first_free, req_last_free, req_keep_reserved, req_query_page));
      end
   end

endmodule

// File: bench/physical_page_region_allocator_unit_tb.sv
// testbench top: stimulus, idling, watchdog and verdict for the page region allocator
`timescale 1ns / 100ps
module physical_page_region_allocator_unit_tb;
   import ppra_pkg::*;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic [1:0]        req_command = CMD_CHECK;
   logic [PAGE_W-1:0] req_region_first = 0, req_region_last = 0;
   logic [PAGE_W-1:0] req_first_free = 0, req_last_free = 0, req_query_page = 0;
   logic              req_keep_reserved = 0;
   logic              rsp_valid, rsp_ready = 0;
   logic [1:0]        rsp_status;
   logic [PAGE_W-1:0] rsp_page, rsp_pages_remaining, rsp_highest_given, rsp_lowest_given;
   logic [PAGE_W-1:0] rsp_lowest_high_given, rsp_highest_high_given, rsp_reserved_given;
   int                fail_count, pending_count, grant_count;
   int                idle_cycles = 0;
   int                item_count = 0;
   int                region_loads = 0;
   logic              stall_mode = 0;

   always #5 clock = ~clock;

   physical_page_region_allocator_unit u_top (.*);
   physical_page_region_allocator_unit_checker u_check (.*);

   // receiver: long stretches of always-ready, then a random stall pattern
   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
      rsp_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
   end

   // watchdog: worst item is a full forward pass plus a backward pass, plus stalls
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("physical_page_region_allocator_unit verification failed");
         $finish;
      end
   end

   // present one item and hold it until accepted
   task automatic send_item(cmd_type cmd, logic [31:0] first, logic [31:0] last,
                            logic [31:0] ff, logic [31:0] lf, logic rsv, logic [31:0] q);
      req_valid <= 1; req_command <= cmd;
      req_region_first <= first; req_region_last <= last;
      req_first_free <= ff; req_last_free <= lf;
      req_keep_reserved <= rsv; req_query_page <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      item_count++;
      if (cmd == CMD_LOAD) region_loads++;
   endtask

   // a well-formed small region somewhere in the page space
   task automatic send_region(logic rsv);
      logic [31:0] b, sz;
      b = $urandom;
      sz = $urandom_range(0, 6);
      send_item(CMD_LOAD, b, b + sz, b + $urandom_range(0, 1), b + sz - $urandom_range(0, 1),
                rsv, $urandom);
   endtask

   task automatic random_item();
      int sel;
      logic [31:0] q;
      sel = $urandom_range(0, 99);
      // q aims near a loaded region base only for sel < 60 with a non-empty table, so checks get a random q
      q = (sel < 60 && u_check.n_regions > 0) ?
          u_check.base_q[$urandom_range(0, 127) % u_check.n_regions] : $urandom;
      if (sel < 8) send_region($urandom_range(0, 3) == 0);
      else if (sel < 10)
         send_item(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, 1'($urandom), $urandom);
      else if (sel < 45) send_item(CMD_LOW, $urandom, $urandom, $urandom, $urandom,
                                   1'($urandom), $urandom);
      else if (sel < 80) send_item(CMD_HIGH, $urandom, $urandom, $urandom, $urandom,
                                   1'($urandom), $urandom);
      else send_item(CMD_CHECK, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
                     q + $urandom_range(0, 2) - 1);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: empty table, extremes, wrap cases, reversed bounds
      send_item(CMD_LOW, 0, 0, 0, 0, 0, 0);
      send_item(CMD_HIGH, 0, 0, 0, 0, 0, 0);
      send_item(CMD_CHECK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_item(CMD_LOAD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
      send_item(CMD_LOW, 0, 0, 0, 0, 0, 0);  // low pointer wraps to zero
      send_item(CMD_LOAD, 0, 0, 1, 0, 1, 0); // empty reserved region
      send_item(CMD_LOAD, 10, 5, 0, 0, 0, 0); // reversed bounds add nothing
      send_item(CMD_LOAD, 0, 32'hFFFF_FFFF, 0, 0, 1, 0); // count saturates
      send_item(CMD_HIGH, 0, 0, 0, 0, 0, 0);
      send_item(CMD_HIGH, 0, 0, 0, 0, 0, 0);
      send_item(CMD_HIGH, 0, 0, 0, 0, 0, 0);  // takes the top page of the high pointer that wrapped below zero
      send_item(CMD_LOW, 0, 0, 0, 0, 0, 0);
      send_item(CMD_CHECK, 0, 0, 0, 0, 0, 32'hFFFF_FFF5);
      send_item(CMD_CHECK, 0, 0, 0, 0, 0, 7);
      drain();

      // random part in bursts, table fills and overflows along the way
      while (item_count < 1150) begin
         repeat ($urandom_range(1, 20)) begin
            if (region_loads < 140 && $urandom_range(0, 9) == 0)
               send_region(1'($urandom_range(0, 1)));
            else random_item();
         end
         if ($urandom_range(0, 40) == 0) drain();
         else begin
            req_valid <= 0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end
      end
      // force both full conditions if not yet hit
      while (region_loads < 135) send_region(region_loads % 3 == 0);
      send_item(CMD_LOAD, 1, 2, 1, 2, 1, 0);
      send_item(CMD_HIGH, 0, 0, 0, 0, 0, 0);
      drain();
      repeat (300) @(negedge clock);

      $display("ran %0d items, %0d results checked, %0d regions in table", item_count,
               grant_count, u_check.n_regions);
      if (fail_count == 0 && pending_count == 0)
         $display("physical_page_region_allocator_unit verification clean");
      else
         $display("physical_page_region_allocator_unit verification failed");
      $finish;
   end

endmodule
